// ===== rtl/qpd_pkg.sv =====
`default_nettype none

package qpd_pkg;

  localparam int MAX_BLANK_RUN_DEF = 32;

  // characters the decoder looks for
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // decode modes; while failed the mode register holds the error status
  localparam logic [2:0] MODE_NORMAL    = 3'd0;
  localparam logic [2:0] MODE_BLANKS    = 3'd1;
  localparam logic [2:0] MODE_EQ        = 3'd2;
  localparam logic [2:0] MODE_EQ_BLANKS = 3'd3;
  localparam logic [2:0] MODE_HEX2      = 3'd4;

  // result status codes
  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR = 3'd1;
  localparam logic [2:0] ST_BAD_HEX  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_END      = 3'd4;

  typedef struct packed {
    logic       blank;
    logic       tab;
    logic       newline;
    logic       equals;
    logic       hex_ok;
    logic [3:0] hex_val;
  } char_class_t;

endpackage

`default_nettype wire

// ===== rtl/qpd_byte_if.sv =====
`default_nettype none

interface qpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source(output valid, output in_byte, output end_of_stream, input ready);
  modport sink(input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

// ===== rtl/qpd_result_if.sv =====
`default_nettype none

interface qpd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source(output valid, output out_byte, output status, output last, input ready);
  modport sink(input valid, input out_byte, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/qpd_ram.sv =====
`default_nettype none

module qpd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                            wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/qpd_char_class.sv =====
`default_nettype none

module qpd_char_class (
  input  wire logic [7:0]         char_in,
  output qpd_pkg::char_class_t    cls
);

  logic is_digit;
  logic is_upper;
  logic is_lower;

  always_comb begin
    is_digit = (char_in >= qpd_pkg::CH_ZERO) && (char_in <= qpd_pkg::CH_ZERO + 8'd9);
    is_upper = (char_in >= qpd_pkg::CH_UA) && (char_in <= qpd_pkg::CH_UA + 8'd5);
    is_lower = (char_in >= qpd_pkg::CH_LA) && (char_in <= qpd_pkg::CH_LA + 8'd5);

    cls.tab     = (char_in == qpd_pkg::CH_TAB);
    cls.blank   = (char_in == qpd_pkg::CH_SPACE) || cls.tab;
    cls.newline = (char_in == qpd_pkg::CH_NL);
    cls.equals  = (char_in == qpd_pkg::CH_EQ);
    cls.hex_ok  = is_digit || is_upper || is_lower;

    priority if (is_upper) begin
      cls.hex_val = 4'(char_in - qpd_pkg::CH_UA + 8'd10);
    end else if (is_lower) begin
      cls.hex_val = 4'(char_in - qpd_pkg::CH_LA + 8'd10);
    end else begin
      cls.hex_val = 4'(char_in - qpd_pkg::CH_ZERO);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/quoted_printable_decoder.sv =====
// Quoted-printable decoder.
// coded: one encoded byte per item, or an end-of-stream mark (end_of_stream
// high, in_byte ignored). decoded: decoded bytes and status items; last marks
// the final result caused by one input item, and an item may cause none.
// Both channels move an item when valid and ready are high at a clock edge.
// An item is registered when it is taken and worked on in the exec state;
// ready is high only while the sequencer is idle, so no new item is taken
// before the last one is through. A held run of spaces and tabs leaves the
// blank store one entry per cycle, while the output register is free,
// through its single read port; the byte that ended the run is worked on
// after it. Every step, with or without a result, waits for the output
// register to be free, so a stalled receiver stalls the sequencer and in
// turn the input. Errors are sticky: every later item gives one result with
// the same error status. After the end mark every item gives one end result.
// rst (synchronous, active high) clears the mode, the run length, the error
// and end flags and the output valid; the blank store needs no clearing.
`default_nettype none

module quoted_printable_decoder #(
  parameter int MAX_BLANK_RUN = qpd_pkg::MAX_BLANK_RUN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  qpd_byte_if.sink         coded,
  qpd_result_if.source     decoded
);

  localparam int CW = $clog2(MAX_BLANK_RUN + 1);
  localparam int IW = (MAX_BLANK_RUN > 1) ? $clog2(MAX_BLANK_RUN) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_TAIL  = 2'd3;

  logic [1:0]  state, state_next;
  logic [2:0]  mode, mode_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next, idx_inc;
  logic [3:0]  high, high_next;
  logic        finished, finished_next;
  logic        failed, failed_next;

  logic [7:0]  byte_r;
  logic        eos_r;

  logic        out_valid;
  logic [7:0]  out_byte_r;
  logic [2:0]  out_status_r;
  logic        out_last_r;

  logic        slot_free;
  logic        emit;
  logic [7:0]  emit_byte;
  logic [2:0]  emit_status;
  logic        emit_last;
  logic        do_normal;
  logic        do_fail;
  logic [2:0]  fail_code;
  logic        tail_emits;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          rd_kind;

  qpd_pkg::char_class_t cls;

  qpd_char_class u_class (
    .char_in (byte_r),
    .cls     (cls)
  );

  qpd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BLANK_RUN)
  ) u_blanks (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cls.tab),
    .rd_addr (idx_next[IW-1:0]),
    .rd_data (rd_kind)
  );

  assign slot_free      = !out_valid || decoded.ready;
  assign coded.ready    = (state == S_IDLE) && !rst;
  assign decoded.valid  = out_valid;
  assign decoded.out_byte = out_byte_r;
  assign decoded.status = out_status_r;
  assign decoded.last   = out_last_r;

  assign idx_inc    = idx + CW'(1);
  // the byte after a flushed run gives a result of its own unless it starts a new run or an escape
  assign tail_emits = eos_r || !(cls.blank || cls.equals);

  always_comb begin
    state_next    = state;
    mode_next     = mode;
    count_next    = count;
    idx_next      = idx;
    high_next     = high;
    finished_next = finished;
    failed_next   = failed;
    emit          = 1'b0;
    emit_byte     = 8'd0;
    emit_status   = qpd_pkg::ST_DATA;
    emit_last     = 1'b1;
    do_normal     = 1'b0;
    do_fail       = 1'b0;
    fail_code     = qpd_pkg::ST_BAD_HEX;
    wr_en         = 1'b0;
    wr_addr       = count[IW-1:0];

    unique case (state)
      S_IDLE: begin
        if (coded.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_next = S_IDLE;
          priority if (failed) begin
            emit        = 1'b1;
            emit_status = mode;
          end else if (finished) begin
            emit        = 1'b1;
            emit_status = qpd_pkg::ST_END;
          end else begin
            unique case (mode)
              qpd_pkg::MODE_BLANKS: begin
                priority if (eos_r || !(cls.blank || cls.newline)) begin
                  idx_next   = '0;
                  state_next = S_FLUSH;
                end else if (cls.blank) begin
                  if (count >= CW'(MAX_BLANK_RUN)) begin
                    do_fail   = 1'b1;
                    fail_code = qpd_pkg::ST_OVERFLOW;
                  end else begin
                    wr_en      = 1'b1;
                    count_next = count + CW'(1);
                  end
                end else begin
                  // newline drops the held run
                  count_next = '0;
                  mode_next  = qpd_pkg::MODE_NORMAL;
                  emit       = 1'b1;
                  emit_byte  = qpd_pkg::CH_NL;
                end
              end
              qpd_pkg::MODE_EQ: begin
                priority if (eos_r) begin
                  finished_next = 1'b1;
                  mode_next     = qpd_pkg::MODE_NORMAL;
                  emit          = 1'b1;
                  emit_status   = qpd_pkg::ST_END;
                end else if (cls.blank) begin
                  mode_next = qpd_pkg::MODE_EQ_BLANKS;
                end else if (cls.newline) begin
                  mode_next = qpd_pkg::MODE_NORMAL;
                end else if (cls.hex_ok) begin
                  high_next = cls.hex_val;
                  mode_next = qpd_pkg::MODE_HEX2;
                end else begin
                  do_fail   = 1'b1;
                  fail_code = qpd_pkg::ST_BAD_HEX;
                end
              end
              qpd_pkg::MODE_EQ_BLANKS: begin
                priority if (eos_r) begin
                  do_fail   = 1'b1;
                  fail_code = qpd_pkg::ST_BAD_CHAR;
                end else if (cls.newline) begin
                  mode_next = qpd_pkg::MODE_NORMAL;
                end else if (!cls.blank) begin
                  do_fail   = 1'b1;
                  fail_code = qpd_pkg::ST_BAD_CHAR;
                end else begin
                  mode_next = qpd_pkg::MODE_EQ_BLANKS;
                end
              end
              qpd_pkg::MODE_HEX2: begin
                if (eos_r || !cls.hex_ok) begin
                  do_fail   = 1'b1;
                  fail_code = qpd_pkg::ST_BAD_HEX;
                end else begin
                  emit      = 1'b1;
                  emit_byte = {high, cls.hex_val};
                  mode_next = qpd_pkg::MODE_NORMAL;
                end
              end
              default: begin
                if (eos_r) begin
                  finished_next = 1'b1;
                  mode_next     = qpd_pkg::MODE_NORMAL;
                  emit          = 1'b1;
                  emit_status   = qpd_pkg::ST_END;
                end else begin
                  do_normal = 1'b1;
                end
              end
            endcase
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = rd_kind ? qpd_pkg::CH_TAB : qpd_pkg::CH_SPACE;
          emit_last = (idx_inc == count) && !tail_emits;
          idx_next  = idx_inc;
          if (idx_inc == count) begin
            count_next = '0;
            state_next = S_TAIL;
          end
        end
      end
      default: begin
        if (slot_free) begin
          state_next = S_IDLE;
          if (eos_r) begin
            finished_next = 1'b1;
            mode_next     = qpd_pkg::MODE_NORMAL;
            emit          = 1'b1;
            emit_status   = qpd_pkg::ST_END;
          end else begin
            do_normal = 1'b1;
          end
        end
      end
    endcase

    if (do_normal) begin
      priority if (cls.blank) begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        count_next = CW'(1);
        mode_next  = qpd_pkg::MODE_BLANKS;
      end else if (cls.equals) begin
        mode_next = qpd_pkg::MODE_EQ;
      end else begin
        emit      = 1'b1;
        emit_byte = byte_r;
        mode_next = qpd_pkg::MODE_NORMAL;
      end
    end

    if (do_fail) begin
      failed_next = 1'b1;
      mode_next   = fail_code;
      count_next  = '0;
      emit        = 1'b1;
      emit_byte   = 8'd0;
      emit_status = fail_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= qpd_pkg::MODE_NORMAL;
      count    <= '0;
      idx      <= '0;
      high     <= '0;
      finished <= 1'b0;
      failed   <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      count    <= count_next;
      idx      <= idx_next;
      high     <= high_next;
      finished <= finished_next;
      failed   <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (coded.valid && coded.ready) begin
      byte_r <= coded.in_byte;
      eos_r  <= coded.end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (decoded.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r   <= emit_byte;
      out_status_r <= emit_status;
      out_last_r   <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qpd_checker.sv =====
`default_nettype none

module qpd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] status,
  input wire logic       last
);

  // a stalled result holds still
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
      && $stable(last))
    else $error("stalled result changed");

  // status items carry a zero byte and always close their item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != qpd_pkg::ST_DATA) |-> (out_byte == 8'd0) && last)
    else $error("status item with data or not last");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= qpd_pkg::ST_END)
    else $error("status code out of range");

  // an end item can only be followed by more end items
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (status == qpd_pkg::ST_END) ##1 out_valid
      |-> status == qpd_pkg::ST_END)
    else $error("result after end");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind quoted_printable_decoder qpd_checker u_qpd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (decoded.valid),
  .out_ready (decoded.ready),
  .out_byte  (decoded.out_byte),
  .status    (decoded.status),
  .last      (decoded.last)
);

`default_nettype wire

// ===== tb/sv/qpd_decode_monitor.sv =====
module qpd_decode_monitor #(
  parameter int MAX_BLANK_RUN = qpd_pkg::MAX_BLANK_RUN_DEF
) (
  input  logic   clk,
  input  logic   rst,
  qpd_byte_if    coded,
  qpd_result_if  decoded,
  output int     mismatches,
  output int     pending,
  output int     results_seen,
  output int     data_bytes
);
  timeunit 1ns;
  timeprecision 1ps;
  import qpd_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } qp_result_t;

  // decoder state as seen from the stream
  logic [2:0] mode_q;
  bit         run_tab [MAX_BLANK_RUN];
  int         run_len;
  logic [3:0] high_digit;
  bit         seen_end;
  bit         stuck;

  qp_result_t step_q [$];
  qp_result_t owed_q [$];
  qp_result_t got_r;
  qp_result_t want_r;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic int hex_of(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c - CH_ZERO);
    if (c >= CH_UA && c <= CH_UA + 8'd5) return int'(c - CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LA + 8'd5) return int'(c - CH_LA) + 10;
    return -1;
  endfunction

  task automatic emit(input logic [7:0] b, input logic [2:0] st);
    step_q.push_back('{out_byte: b, status: st, last: 1'b0});
  endtask

  task automatic raise_error(input logic [2:0] st);
    stuck = 1'b1;
    mode_q = st;
    run_len = 0;
    emit(8'h00, st);
  endtask

  task automatic flush_run();
    for (int i = 0; i < run_len; i++) emit(run_tab[i] ? CH_TAB : CH_SPACE, ST_DATA);
    run_len = 0;
  endtask

  task automatic take_plain(input logic [7:0] c);
    if (is_blank(c)) begin
      run_tab[0] = (c == CH_TAB);
      run_len = 1;
      mode_q = MODE_BLANKS;
    end else if (c == CH_EQ) begin
      mode_q = MODE_EQ;
    end else begin
      emit(c, ST_DATA);
      mode_q = MODE_NORMAL;
    end
  endtask

  task automatic close_stream();
    seen_end = 1'b1;
    mode_q = MODE_NORMAL;
    emit(8'h00, ST_END);
  endtask

  task automatic decode_item(input logic [7:0] c, input logic eos);
    int digit;
    step_q.delete();
    if (stuck) begin
      emit(8'h00, mode_q);
    end else if (seen_end) begin
      emit(8'h00, ST_END);
    end else begin
      case (mode_q)
        MODE_BLANKS: begin
          if (eos) begin
            flush_run();
            close_stream();
          end else if (is_blank(c)) begin
            if (run_len >= MAX_BLANK_RUN) begin
              raise_error(ST_OVERFLOW);
            end else begin
              run_tab[run_len] = (c == CH_TAB);
              run_len++;
            end
          end else if (c == CH_NL) begin
            // held blanks before a newline are dropped
            run_len = 0;
            mode_q = MODE_NORMAL;
            emit(CH_NL, ST_DATA);
          end else begin
            flush_run();
            take_plain(c);
          end
        end
        MODE_EQ: begin
          if (eos) begin
            close_stream();
          end else if (is_blank(c)) begin
            mode_q = MODE_EQ_BLANKS;
          end else if (c == CH_NL) begin
            mode_q = MODE_NORMAL;
          end else begin
            digit = hex_of(c);
            if (digit < 0) begin
              raise_error(ST_BAD_HEX);
            end else begin
              high_digit = digit[3:0];
              mode_q = MODE_HEX2;
            end
          end
        end
        MODE_EQ_BLANKS: begin
          if (eos) raise_error(ST_BAD_CHAR);
          else if (c == CH_NL) mode_q = MODE_NORMAL;
          else if (!is_blank(c)) raise_error(ST_BAD_CHAR);
        end
        MODE_HEX2: begin
          digit = eos ? -1 : hex_of(c);
          if (digit < 0) begin
            raise_error(ST_BAD_HEX);
          end else begin
            emit({high_digit, digit[3:0]}, ST_DATA);
            mode_q = MODE_NORMAL;
          end
        end
        default: begin
          if (eos) close_stream();
          else take_plain(c);
        end
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) owed_q.push_back(step_q[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_q = MODE_NORMAL;
      run_len = 0;
      high_digit = 4'h0;
      seen_end = 1'b0;
      stuck = 1'b0;
      owed_q.delete();
      mismatches = 0;
      results_seen = 0;
      data_bytes = 0;
    end else begin
      if (decoded.valid && decoded.ready) begin
        got_r = '{decoded.out_byte, decoded.status, decoded.last};
        results_seen++;
        if (got_r.status == ST_DATA) data_bytes++;
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result with nothing expected: byte %02h status %0d last %0b",
                     $realtime, got_r.out_byte, got_r.status, got_r.last);
        end else begin
          want_r = owed_q.pop_front();
          if (got_r.out_byte !== want_r.out_byte || got_r.status !== want_r.status ||
              got_r.last !== want_r.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: expected byte %02h status %0d last %0b, got %02h %0d %0b",
                       $realtime, want_r.out_byte, want_r.status, want_r.last,
                       got_r.out_byte, got_r.status, got_r.last);
          end
        end
      end
      if (coded.valid && coded.ready) decode_item(coded.in_byte, coded.end_of_stream);
    end
    pending = owed_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qpd_pkg::*;

  localparam int RUN_MAX        = MAX_BLANK_RUN_DEF;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT    = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_UNTIL   = 330;
  localparam int ITEM_TARGET    = 410;

  logic clk;
  logic rst;

  qpd_byte_if   coded_ch ();
  qpd_result_if decoded_ch ();

  int    mismatches;
  int    pending;
  int    results_seen;
  int    data_bytes;
  int    sent_items;
  int    idle_cycles;
  bit    tx_gaps;
  bit    rx_stalls;
  bit    hold_request;
  string ending;

  quoted_printable_decoder DUT (
    .clk     (clk),
    .rst     (rst),
    .coded   (coded_ch),
    .decoded (decoded_ch)
  );

  qpd_decode_monitor decode_mon (
    .clk          (clk),
    .rst          (rst),
    .coded        (coded_ch),
    .decoded      (decoded_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .data_bytes   (data_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // no item moving on either side for too long means a hang
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((coded_ch.valid && coded_ch.ready) || (decoded_ch.valid && decoded_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles, %0d results outstanding", idle_cycles, pending);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    decoded_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        decoded_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        decoded_ch.ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
        decoded_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        decoded_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] any_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_EQ || b == CH_SPACE || b == CH_TAB);
    return b;
  endfunction

  function automatic logic [7:0] any_blank();
    return $urandom_range(0, 1) ? CH_TAB : CH_SPACE;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v) - 8'd10;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos = 1'b0);
    int gap;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      coded_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    coded_ch.valid         <= 1'b1;
    coded_ch.in_byte       <= b;
    coded_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!coded_ch.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_end();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic stop_tx();
    @(negedge clk);
    coded_ch.valid <= 1'b0;
  endtask

  task automatic send_escape(input logic [7:0] v);
    send_byte(CH_EQ);
    send_byte(hex_char(v[7:4]));
    send_byte(hex_char(v[3:0]));
  endtask

  task automatic send_soft_break(input int blanks);
    send_byte(CH_EQ);
    repeat (blanks) send_byte(any_blank());
    send_byte(CH_NL);
  endtask

  // a run of blanks always closed by something that is not a blank
  task automatic send_blank_run(input int n, input int closer);
    repeat (n) send_byte(any_blank());
    case (closer)
      0: send_byte(CH_NL);
      1: send_byte(any_plain());
      default: send_escape(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) send_byte(any_plain());
    else if (pick < 45) send_byte(CH_NL);
    else if (pick < 65) send_escape(8'($urandom_range(0, 255)));
    else if (pick < 75) send_soft_break($urandom_range(0, 3));
    else if (pick < 97) send_blank_run($urandom_range(1, 6), $urandom_range(0, 2));
    else send_blank_run(RUN_MAX, $urandom_range(0, 2));
  endtask

  task automatic send_segment();
    tx_gaps = $urandom_range(0, 1);
    rx_stalls = $urandom_range(0, 1);
    repeat (10) send_token();
  endtask

  task automatic wait_drained();
    stop_tx();
    while (pending != 0) @(negedge clk);
  endtask

  // only one way out of the stream per run, since reset is never repeated
  task automatic finish_stream();
    case ($urandom_range(0, 6))
      0: begin
        ending = "end mark after held blanks";
        repeat ($urandom_range(1, 5)) send_byte(any_blank());
        send_end();
      end
      1: begin
        ending = "end mark right after an equals sign";
        send_byte(CH_EQ);
        send_end();
      end
      2: begin
        ending = "end mark in blanks after an equals sign";
        send_byte(CH_EQ);
        send_byte(any_blank());
        send_end();
      end
      3: begin
        ending = "bad character in a soft break";
        send_byte(CH_EQ);
        send_byte(any_blank());
        send_byte("x");
      end
      4: begin
        ending = "end mark after one hex digit";
        send_byte(CH_EQ);
        send_byte(hex_char(4'($urandom_range(0, 15))));
        send_end();
      end
      5: begin
        ending = "bad hex digit";
        send_byte(CH_EQ);
        send_byte(hex_char(4'($urandom_range(0, 15))));
        send_byte("g");
      end
      default: begin
        ending = "blank run overflow";
        repeat (RUN_MAX + 1) send_byte(any_blank());
      end
    endcase
  endtask

  initial begin
    rst = 1'b1;
    coded_ch.valid = 1'b0;
    coded_ch.in_byte = 8'h00;
    coded_ch.end_of_stream = 1'b0;
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    hold_request = 1'b0;
    sent_items = 0;
    ending = "";
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_NL);
    send_byte(CH_EQ); send_byte("A"); send_byte("9");
    send_byte(CH_EQ); send_byte("0"); send_byte("f");
    send_byte(CH_EQ); send_byte("a"); send_byte("F");
    send_byte(CH_EQ); send_byte(CH_NL);
    send_byte(CH_EQ); send_byte(CH_SPACE); send_byte(CH_TAB); send_byte(CH_NL);
    send_byte(CH_SPACE); send_byte(CH_TAB); send_byte(CH_NL);
    send_byte(CH_TAB); send_byte(CH_SPACE); send_byte("x");
    send_byte(CH_SPACE); send_byte(CH_EQ); send_byte("7"); send_byte("e");

    repeat (3) send_segment();
    // receiver holds off while a full blank run and its flush pile up
    hold_request = 1'b1;
    send_blank_run(RUN_MAX, 1);
    send_segment();
    wait_drained();
    while (sent_items < RANDOM_UNTIL) send_segment();

    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    while (sent_items < ITEM_TARGET) send_token();
    finish_stream();
    repeat (6) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_end();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("%0d items in, %0d results out (%0d data bytes), stream closed by %s",
             sent_items, results_seen, data_bytes, ending);
    $display("covered escapes, soft breaks, blank runs up to %0d, long receiver hold, drain",
             RUN_MAX);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/qpd_pkg.sv
rtl/qpd_byte_if.sv
rtl/qpd_result_if.sv
rtl/qpd_ram.sv
rtl/qpd_char_class.sv
rtl/quoted_printable_decoder.sv
rtl/qpd_checker.sv
tb/sv/qpd_decode_monitor.sv
tb/sv/tb_top.sv
